>>> hdl/pba_pkg.sv
// Shared constants, types and the arctangent table for the point bearing and distance block.
// Used by every module under hdl/; depends on nothing.
`timescale 1ns / 1ps

package pba_pkg;

   localparam int COORD_WIDTH_DEF  = 16;
   localparam int CORDIC_STEPS_DEF = 16;

   // CORDIC: input scaled by 2^GUARD_BITS, 32-bit phase accumulator in 2*pi/2^32 units
   localparam int GUARD_BITS      = 24;
   localparam int TABLE_LEN       = 24;
   localparam int TABLE_IDX_WIDTH = 5;
   localparam int ACC_WIDTH       = 32;

   // distance path: magnitudes clamp at 2^17, radicand = 256 * (ax^2 + ay^2)
   localparam int MAG_WIDTH  = 17;
   localparam int SQ_WIDTH   = 2 * MAG_WIDTH;
   localparam int SUM_WIDTH  = SQ_WIDTH + 1;
   localparam int RAD_WIDTH  = 44;
   localparam int ROOT_WIDTH = RAD_WIDTH / 2;
   localparam int REM_WIDTH  = ROOT_WIDTH + 2;

   localparam int DIST_WIDTH      = 21;
   localparam int BEARING_WIDTH   = 16;
   localparam int RSP_DATA_WIDTH  = ((DIST_WIDTH + BEARING_WIDTH + 7) / 8) * 8;
   localparam int RSP_PAD_WIDTH   = RSP_DATA_WIDTH - DIST_WIDTH - BEARING_WIDTH;

   // one register stage per root bit, plus squaring and summing
   localparam int CORE_DEPTH = ROOT_WIDTH + 2;

   localparam logic [DIST_WIDTH-1:0] DIST_MAX   = '1;
   localparam logic [ACC_WIDTH-1:0]  HALF_TURN  = 32'h8000_0000;
   localparam logic [ACC_WIDTH-1:0]  ROUND_HALF = 32'h0000_8000;

   typedef struct packed {
      logic coincident;
      logic saturate;
   } flag_type;

   typedef struct packed {
      logic [DIST_WIDTH-1:0]    distance;
      logic [BEARING_WIDTH-1:0] bearing;
      logic                     coincident;
   } result_type;

   // atan(2^-i) in units of 2*pi/2^32
   function automatic logic [ACC_WIDTH-1:0] atan_entry(input logic [TABLE_IDX_WIDTH-1:0] idx);
      logic [ACC_WIDTH-1:0] val;
      case (idx)
         5'd0:    val = 32'h20000000;
         5'd1:    val = 32'h12E4051E;
         5'd2:    val = 32'h09FB385B;
         5'd3:    val = 32'h051111D4;
         5'd4:    val = 32'h028B0D43;
         5'd5:    val = 32'h0145D7E1;
         5'd6:    val = 32'h00A2F61E;
         5'd7:    val = 32'h00517C55;
         5'd8:    val = 32'h0028BE53;
         5'd9:    val = 32'h00145F2F;
         5'd10:   val = 32'h000A2F98;
         5'd11:   val = 32'h000517CC;
         5'd12:   val = 32'h00028BE6;
         5'd13:   val = 32'h000145F3;
         5'd14:   val = 32'h0000A2FA;
         5'd15:   val = 32'h0000517D;
         5'd16:   val = 32'h000028BE;
         5'd17:   val = 32'h0000145F;
         5'd18:   val = 32'h00000A30;
         5'd19:   val = 32'h00000518;
         5'd20:   val = 32'h0000028C;
         5'd21:   val = 32'h00000146;
         5'd22:   val = 32'h000000A3;
         5'd23:   val = 32'h00000051;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

>>> hdl/point_bearing_and_distance.sv
// Top level of the point bearing and distance block: handshake, valid pipeline, assembly.
// Instantiates pba_prep, pba_cordic, pba_sqrt and pba_outbuf; depends on pba_pkg.
`timescale 1ns / 1ps

// Takes a start and an end point per input word and returns the distance between them
// (UQ17.4, saturating) and the screen bearing of the end point (2*pi/65536 units, 0 when
// the points coincide, with tuser set). The pipeline accepts one word per clock and
// delivers one result per clock when the result side keeps up. A word passes through two
// front stages, 24 core stages sized by the 22-bit square root (one root bit per stage,
// the CORDIC rotations run alongside), and the output buffer. That two-entry buffer
// absorbs a stalled result channel; when both entries are taken the whole pipeline holds
// and req_tready drops.
module point_bearing_and_distance #(
   parameter int COORD_WIDTH  = pba_pkg::COORD_WIDTH_DEF,
   parameter int CORDIC_STEPS = pba_pkg::CORDIC_STEPS_DEF,
   localparam int REQ_DATA_WIDTH = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // start_x, start_y, end_x, end_y (COORD_WIDTH each, signed), zero pad
   input  logic [REQ_DATA_WIDTH-1:0]            req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // distance [20:0], bearing [36:21], zero pad
   output logic [pba_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   // coincident
   output logic                                 rsp_tuser
);

   localparam int W    = COORD_WIDTH;
   localparam int CW   = COORD_WIDTH + pba_pkg::GUARD_BITS + 3;
   localparam int PIPE = pba_pkg::CORE_DEPTH + 2;

   logic                 pipe_en;
   logic [PIPE-1:0]      vld_ff, vld_in;

   logic signed [W-1:0]  start_x, start_y, end_x, end_y;
   logic signed [CW-1:0] x0, y0;
   logic                 half_turn;
   logic [pba_pkg::MAG_WIDTH-1:0]  mag_x, mag_y;
   pba_pkg::flag_type              pre_flags, core_flags;
   logic [pba_pkg::ACC_WIDTH-1:0]  acc;
   logic [pba_pkg::ROOT_WIDTH-1:0] root;
   logic [pba_pkg::REM_WIDTH-1:0]  remainder;
   pba_pkg::result_type            rsp_word;

   assign start_x = req_tdata[W-1:0];
   assign start_y = req_tdata[2*W-1:W];
   assign end_x   = req_tdata[3*W-1:2*W];
   assign end_y   = req_tdata[4*W-1:3*W];

   assign req_tready = pipe_en;

   // advance every stage together; valid bits ride along
   assign vld_in = {vld_ff[PIPE-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= vld_in;
      end
   end

   pba_prep #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_prep (
      .clock     (clock),
      .en        (pipe_en),
      .start_x   (start_x),
      .start_y   (start_y),
      .end_x     (end_x),
      .end_y     (end_y),
      .x0        (x0),
      .y0        (y0),
      .half_turn (half_turn),
      .mag_x     (mag_x),
      .mag_y     (mag_y),
      .flags     (pre_flags)
   );

   pba_cordic #(
      .COORD_WIDTH  (COORD_WIDTH),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock     (clock),
      .en        (pipe_en),
      .x0        (x0),
      .y0        (y0),
      .half_turn (half_turn),
      .acc       (acc)
   );

   pba_sqrt u_sqrt (
      .clock     (clock),
      .en        (pipe_en),
      .mag_x     (mag_x),
      .mag_y     (mag_y),
      .flags_i   (pre_flags),
      .root      (root),
      .remainder (remainder),
      .flags_o   (core_flags)
   );

   pba_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[PIPE-1]),
      .in_ready  (pipe_en),
      .root      (root),
      .remainder (remainder),
      .flags     (core_flags),
      .acc       (acc),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_word)
   );

   assign rsp_tdata = {{pba_pkg::RSP_PAD_WIDTH{1'b0}}, rsp_word.bearing, rsp_word.distance};
   assign rsp_tuser = rsp_word.coincident;

   a_coincident_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("coincident result with nonzero distance or bearing");

   a_hold_frozen : assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(vld_ff))
      else $error("pipeline valid bits moved while held");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> (vld_ff == '0 && !rsp_tvalid))
      else $error("pipeline not empty after reset");

   a_full_means_waiting : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result waiting");

endmodule

>>> hdl/pba_prep.sv
// Front stages: coordinate differences, magnitudes, saturation and coincidence flags,
// and the half-plane fold that seeds the CORDIC. Depends on pba_pkg.
`timescale 1ns / 1ps

module pba_prep #(
   parameter int COORD_WIDTH = pba_pkg::COORD_WIDTH_DEF
) (
   input  logic                                                    clock,
   input  logic                                                    en,
   input  logic signed [COORD_WIDTH-1:0]                           start_x,
   input  logic signed [COORD_WIDTH-1:0]                           start_y,
   input  logic signed [COORD_WIDTH-1:0]                           end_x,
   input  logic signed [COORD_WIDTH-1:0]                           end_y,
   output logic signed [COORD_WIDTH+pba_pkg::GUARD_BITS+2:0]       x0,
   output logic signed [COORD_WIDTH+pba_pkg::GUARD_BITS+2:0]       y0,
   output logic                                                    half_turn,
   output logic [pba_pkg::MAG_WIDTH-1:0]                           mag_x,
   output logic [pba_pkg::MAG_WIDTH-1:0]                           mag_y,
   output pba_pkg::flag_type                                       flags
);

   localparam int DW  = COORD_WIDTH + 1;
   localparam int CW  = COORD_WIDTH + pba_pkg::GUARD_BITS + 3;
   localparam int EXT = (COORD_WIDTH > pba_pkg::MAG_WIDTH) ? COORD_WIDTH : pba_pkg::MAG_WIDTH;

   logic signed [DW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [DW-1:0]        abs_x, abs_y;
   logic [EXT-1:0]       ext_x, ext_y;
   logic signed [CW-1:0] xe, ye;

   logic signed [CW-1:0]           x0_ff, x0_in, y0_ff, y0_in;
   logic                           half_ff, half_in;
   logic [pba_pkg::MAG_WIDTH-1:0]  magx_ff, magx_in, magy_ff, magy_in;
   pba_pkg::flag_type              flags_ff, flags_in;

   assign dx_in = {end_x[COORD_WIDTH-1], end_x} - {start_x[COORD_WIDTH-1], start_x};
   assign dy_in = {end_y[COORD_WIDTH-1], end_y} - {start_y[COORD_WIDTH-1], start_y};

   always_comb begin
      abs_x = dx_ff[DW-1] ? -dx_ff : dx_ff;
      abs_y = dy_ff[DW-1] ? -dy_ff : dy_ff;
      ext_x = EXT'(abs_x[COORD_WIDTH-1:0]);
      ext_y = EXT'(abs_y[COORD_WIDTH-1:0]);
      magx_in = ext_x[pba_pkg::MAG_WIDTH-1:0];
      magy_in = ext_y[pba_pkg::MAG_WIDTH-1:0];
      flags_in.saturate   = ((ext_x >> pba_pkg::MAG_WIDTH) != '0) ||
                            ((ext_y >> pba_pkg::MAG_WIDTH) != '0);
      flags_in.coincident = (dx_ff == '0) && (dy_ff == '0);

      // screen y grows downward, so the vector is (dx, -dy); fold the left half-plane
      xe = {{2{dx_ff[DW-1]}}, dx_ff, {pba_pkg::GUARD_BITS{1'b0}}};
      ye = {{2{dy_ff[DW-1]}}, dy_ff, {pba_pkg::GUARD_BITS{1'b0}}};
      half_in = dx_ff[DW-1];
      x0_in   = half_in ? -xe : xe;
      y0_in   = half_in ? ye : -ye;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         x0_ff    <= x0_in;
         y0_ff    <= y0_in;
         half_ff  <= half_in;
         magx_ff  <= magx_in;
         magy_ff  <= magy_in;
         flags_ff <= flags_in;
      end
   end

   assign x0        = x0_ff;
   assign y0        = y0_ff;
   assign half_turn = half_ff;
   assign mag_x     = magx_ff;
   assign mag_y     = magy_ff;
   assign flags     = flags_ff;

endmodule

>>> hdl/pba_cordic.sv
// Vectoring CORDIC, one micro-rotation per register stage, padded to the core depth.
// Depends on pba_pkg for the arctangent table and widths.
`timescale 1ns / 1ps

module pba_cordic #(
   parameter int COORD_WIDTH  = pba_pkg::COORD_WIDTH_DEF,
   parameter int CORDIC_STEPS = pba_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                              clock,
   input  logic                                              en,
   input  logic signed [COORD_WIDTH+pba_pkg::GUARD_BITS+2:0] x0,
   input  logic signed [COORD_WIDTH+pba_pkg::GUARD_BITS+2:0] y0,
   input  logic                                              half_turn,
   output logic [pba_pkg::ACC_WIDTH-1:0]                     acc
);

   localparam int CW    = COORD_WIDTH + pba_pkg::GUARD_BITS + 3;
   localparam int AW    = pba_pkg::ACC_WIDTH;
   localparam int DEPTH = pba_pkg::CORE_DEPTH;
   localparam int NSTEP = (CORDIC_STEPS < pba_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                               : pba_pkg::TABLE_LEN;

   // the last step needs only the sign of y, the one before only x for y
   logic signed [CW-1:0] x_ff [NSTEP-2];
   logic signed [CW-1:0] y_ff [NSTEP-1];
   logic [AW-1:0]        acc_ff [DEPTH];

   for (genvar k = 0; k < DEPTH; k++) begin : g_stage
      logic [AW-1:0] acc_p, acc_in;

      if (k == 0) begin : g_first
         assign acc_p = half_turn ? pba_pkg::HALF_TURN : '0;
      end else begin : g_next
         assign acc_p = acc_ff[k-1];
      end

      if (k < NSTEP) begin : g_rot
         logic signed [CW-1:0] xp, yp, xn, yn;
         logic [AW-1:0]        ang;

         if (k == 0) begin : g_src0
            assign xp = x0;
            assign yp = y0;
         end else if (k < NSTEP - 1) begin : g_srcn
            assign xp = x_ff[k-1];
            assign yp = y_ff[k-1];
         end else begin : g_srcl
            assign xp = '0;
            assign yp = y_ff[k-1];
         end

         assign ang = pba_pkg::atan_entry(pba_pkg::TABLE_IDX_WIDTH'(k));

         always_comb begin
            if (!yp[CW-1]) begin
               xn     = xp + (yp >>> k);
               yn     = yp - (xp >>> k);
               acc_in = acc_p + ang;
            end else begin
               xn     = xp - (yp >>> k);
               yn     = yp + (xp >>> k);
               acc_in = acc_p - ang;
            end
         end

         if (k < NSTEP - 2) begin : g_keepx
            always_ff @(posedge clock) begin
               if (en) begin
                  x_ff[k] <= xn;
               end
            end
         end
         if (k < NSTEP - 1) begin : g_keepy
            always_ff @(posedge clock) begin
               if (en) begin
                  y_ff[k] <= yn;
               end
            end
         end
      end else begin : g_hold
         assign acc_in = acc_p;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[k] <= acc_in;
         end
      end
   end

   assign acc = acc_ff[DEPTH-1];

endmodule

>>> hdl/pba_sqrt.sv
// Distance path: squares, radicand sum, then a restoring square root one bit per stage.
// Carries the saturate and coincident flags alongside. Depends on pba_pkg.
`timescale 1ns / 1ps

module pba_sqrt (
   input  logic                             clock,
   input  logic                             en,
   input  logic [pba_pkg::MAG_WIDTH-1:0]    mag_x,
   input  logic [pba_pkg::MAG_WIDTH-1:0]    mag_y,
   input  pba_pkg::flag_type                flags_i,
   output logic [pba_pkg::ROOT_WIDTH-1:0]   root,
   output logic [pba_pkg::REM_WIDTH-1:0]    remainder,
   output pba_pkg::flag_type                flags_o
);

   localparam int RB    = pba_pkg::ROOT_WIDTH;
   localparam int RW    = pba_pkg::REM_WIDTH;
   localparam int SW    = pba_pkg::RAD_WIDTH;
   localparam int DEPTH = pba_pkg::CORE_DEPTH;

   logic [pba_pkg::SQ_WIDTH-1:0]  sqx_ff, sqy_ff;
   logic [pba_pkg::SUM_WIDTH-1:0] sum;
   logic [SW-1:0]                 rad_ff [RB];
   logic [RW-1:0]                 rem_ff [RB];
   logic [RB-1:0]                 root_ff [RB];
   pba_pkg::flag_type             flag_ff [DEPTH];

   assign sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff     <= mag_x * mag_x;
         sqy_ff     <= mag_y * mag_y;
         flag_ff[0] <= flags_i;
         rad_ff[0]  <= {1'b0, sum, 8'h00};
         flag_ff[1] <= flag_ff[0];
      end
   end

   for (genvar d = 0; d < RB; d++) begin : g_digit
      logic [RW-1:0] rem_p, rem_sh, trial, rem_n;
      logic [RB-1:0] root_p, root_n;
      logic          fits;

      if (d == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
      end else begin : g_next
         assign rem_p  = rem_ff[d-1];
         assign root_p = root_ff[d-1];
      end

      always_comb begin
         // bring down the next two radicand bits and try root*4+1
         rem_sh = {rem_p[RW-3:0], rad_ff[d][SW-1:SW-2]};
         trial  = {root_p, 2'b01};
         fits   = rem_sh >= trial;
         rem_n  = fits ? rem_sh - trial : rem_sh;
         root_n = {root_p[RB-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[d]    <= rem_n;
            root_ff[d]   <= root_n;
            flag_ff[d+2] <= flag_ff[d+1];
         end
      end

      if (d < RB - 1) begin : g_shift
         always_ff @(posedge clock) begin
            if (en) begin
               rad_ff[d+1] <= {rad_ff[d][SW-3:0], 2'b00};
            end
         end
      end
   end

   assign root      = root_ff[RB-1];
   assign remainder = rem_ff[RB-1];
   assign flags_o   = flag_ff[DEPTH-1];

endmodule

>>> hdl/pba_outbuf.sv
// Final rounding and saturation, then a two-entry output buffer that parts the pipeline
// from the result channel. Depends on pba_pkg.
`timescale 1ns / 1ps

module pba_outbuf (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [pba_pkg::ROOT_WIDTH-1:0]   root,
   input  logic [pba_pkg::REM_WIDTH-1:0]    remainder,
   input  pba_pkg::flag_type                flags,
   input  logic [pba_pkg::ACC_WIDTH-1:0]    acc,
   output logic                             out_valid,
   input  logic                             out_ready,
   output pba_pkg::result_type              out_data
);

   localparam int RB = pba_pkg::ROOT_WIDTH;

   logic [RB:0]                   rounded;
   logic                          too_big;
   logic [pba_pkg::ACC_WIDTH-1:0] bear_sum;
   pba_pkg::result_type           result;

   logic [1:0]          count_ff, count_in;
   logic [1:0]          pos;
   pba_pkg::result_type slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic                push, pop;

   always_comb begin
      // round to nearest: bump when the remainder exceeds the root
      rounded  = {1'b0, root} + (RB+1)'(remainder > {2'b00, root});
      too_big  = rounded > (RB+1)'(pba_pkg::DIST_MAX);
      bear_sum = acc + pba_pkg::ROUND_HALF;
      result.coincident = flags.coincident;
      if (flags.coincident) begin
         result.distance = '0;
         result.bearing  = '0;
      end else begin
         result.distance = (flags.saturate || too_big) ? pba_pkg::DIST_MAX
                                                        : rounded[pba_pkg::DIST_WIDTH-1:0];
         result.bearing  = bear_sum[pba_pkg::ACC_WIDTH-1 -: pba_pkg::BEARING_WIDTH];
      end
   end

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot0_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in = count_ff + 2'(push) - 2'(pop);
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (pop) begin
         slot0_in = slot1_ff;
      end
      // write behind whatever stays in the buffer
      pos = count_ff - 2'(pop);
      if (push) begin
         if (pos[0]) begin
            slot1_in = result;
         end else begin
            slot0_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

>>> dv/tb_point_bearing_and_distance.sv
// Self-checking testbench for point_bearing_and_distance: streams point pairs with bursty
// input and a stalling result side, and checks every result word against a directed
// table entry or a local model. Depends on pba_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module tb_point_bearing_and_distance;

   localparam int COORD_W      = pba_pkg::COORD_WIDTH_DEF;
   localparam int REQ_W        = ((4 * COORD_W + 7) / 8) * 8;
   localparam int DIST_W       = pba_pkg::DIST_WIDTH;
   localparam int BEARING_W    = pba_pkg::BEARING_WIDTH;
   localparam int RANDOM_ITEMS = 1750;
   localparam int DRAIN_CYCLES = 60;

   typedef logic signed [COORD_W-1:0] coord_type;

   localparam coord_type C_MIN  = 16'sh8000;
   localparam coord_type C_MAX  = 16'sh7FFF;
   localparam coord_type C_NEG1 = -16'sd1;

   // atan(2^-i) as a fraction of a full turn, 2^32 per turn
   localparam logic [31:0] ATAN_TURN [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      coord_type            sx;
      coord_type            sy;
      coord_type            ex;
      coord_type            ey;
      logic                 typed;
      logic [DIST_W-1:0]    exp_dist;
      logic [BEARING_W-1:0] brg;
      logic                 coin;
   } dir_row_type;

   localparam int DIR_LEN = 20;

   // rows with typed set carry their expected result; the others go through the model
   localparam dir_row_type DIRECTED_ROWS [DIR_LEN] = '{
      '{16'sd0,  16'sd0,  16'sd0,  16'sd0,  1'b1, 21'd0,       16'd0,     1'b1},
      '{C_MIN,   C_MIN,   C_MIN,   C_MIN,   1'b1, 21'd0,       16'd0,     1'b1},
      '{C_MAX,   C_MAX,   C_MAX,   C_MAX,   1'b1, 21'd0,       16'd0,     1'b1},
      '{16'sd0,  16'sd0,  16'sd1,  16'sd0,  1'b1, 21'd16,      16'd0,     1'b0},
      '{16'sd0,  16'sd0,  C_NEG1,  16'sd0,  1'b1, 21'd16,      16'd32768, 1'b0},
      '{C_MIN,   16'sd0,  C_MAX,   16'sd0,  1'b1, 21'd1048560, 16'd0,     1'b0},
      '{C_MAX,   16'sd5,  C_MIN,   16'sd5,  1'b1, 21'd1048560, 16'd32768, 1'b0},
      '{16'sd0,  16'sd0,  16'sd0,  C_NEG1,  1'b0, 21'd0,       16'd0,     1'b0},
      '{16'sd0,  16'sd0,  16'sd0,  16'sd1,  1'b0, 21'd0,       16'd0,     1'b0},
      '{16'sd0,  C_MAX,   16'sd0,  C_MIN,   1'b0, 21'd0,       16'd0,     1'b0},
      '{16'sd0,  C_MIN,   16'sd0,  C_MAX,   1'b0, 21'd0,       16'd0,     1'b0},
      '{C_MIN,   C_MIN,   C_MAX,   C_MAX,   1'b0, 21'd0,       16'd0,     1'b0},
      '{C_MAX,   C_MIN,   C_MIN,   C_MAX,   1'b0, 21'd0,       16'd0,     1'b0},
      '{C_MIN,   C_MAX,   C_MAX,   C_MIN,   1'b0, 21'd0,       16'd0,     1'b0},
      '{C_MAX,   C_MAX,   C_MIN,   C_MIN,   1'b0, 21'd0,       16'd0,     1'b0},
      '{16'sd0,  16'sd0,  16'sd3,  -16'sd4, 1'b0, 21'd0,       16'd0,     1'b0},
      '{16'sd100, 16'sd100, 16'sd101, 16'sd99, 1'b0, 21'd0,    16'd0,     1'b0},
      '{16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555, 1'b0, 21'd0, 16'd0,   1'b0},
      '{16'shAAAA, 16'sh5555, 16'sh5555, 16'shAAAA, 1'b0, 21'd0, 16'd0,   1'b0},
      '{-16'sd7, 16'sd1,  -16'sd7, 16'sd2,  1'b0, 21'd0,       16'd0,     1'b0}
   };

   logic                               clock;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [REQ_W-1:0]                   req_tdata  = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [pba_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                               rsp_tuser;

   pba_pkg::result_type pending_results [$];
   int                  mismatches = 0;

   point_bearing_and_distance u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic pba_pkg::result_type bearing_and_distance(coord_type sx, coord_type sy,
                                                                coord_type ex, coord_type ey);
      pba_pkg::result_type res;
      longint              dx, dy, x, y, xs, ys;
      longint unsigned     ax, ay, rad, rem, root, bitv;
      logic [31:0]         phase, rounded;
      dx = longint'(ex) - longint'(sx);
      dy = longint'(ey) - longint'(sy);
      res = '0;
      if (dx == 0 && dy == 0) begin
         res.coincident = 1'b1;
         return res;
      end
      // distance: rounded integer root of 256 * (dx^2 + dy^2)
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      rad = 256 * (ax * ax + ay * ay);
      rem = rad;
      root = 0;
      bitv = 64'h1 << 62;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem  = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      if (rem > root) root++;
      if (ax >= 131072 || ay >= 131072 || root > pba_pkg::DIST_MAX)
         res.distance = pba_pkg::DIST_MAX;
      else
         res.distance = root[DIST_W-1:0];
      // bearing: vectoring CORDIC on (dx, -dy), left half folded over by a half turn
      x = dx <<< pba_pkg::GUARD_BITS;
      y = -dy <<< pba_pkg::GUARD_BITS;
      phase = '0;
      if (x < 0) begin
         x = -x;
         y = -y;
         phase = pba_pkg::HALF_TURN;
      end
      for (int i = 0; i < pba_pkg::CORDIC_STEPS_DEF && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            phase = phase + ATAN_TURN[i];
         end else begin
            x = x - ys;
            y = y + xs;
            phase = phase - ATAN_TURN[i];
         end
      end
      rounded = phase + pba_pkg::ROUND_HALF;
      res.bearing = rounded[31:16];
      return res;
   endfunction

   function automatic coord_type corner_coord();
      case ($urandom_range(0, 5))
         0:       return C_MIN;
         1:       return C_MAX;
         2:       return C_NEG1;
         3:       return '0;
         4:       return 16'sd1;
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic void random_pair(output coord_type sx, output coord_type sy,
                                       output coord_type ex, output coord_type ey);
      int d;
      sx = coord_type'($urandom);
      sy = coord_type'($urandom);
      ex = coord_type'($urandom);
      ey = coord_type'($urandom);
      case ($urandom_range(0, 9))
         4: begin
            // short vector, wraps freely near the edges
            ex = coord_type'(int'(sx) + int'($urandom_range(0, 16)) - 8);
            ey = coord_type'(int'(sy) + int'($urandom_range(0, 16)) - 8);
         end
         5: begin
            if ($urandom_range(0, 1) == 0) ex = sx;
            else ey = sy;
         end
         6: begin
            d  = int'($urandom_range(1, 20000));
            ex = coord_type'(int'(sx) + (($urandom_range(0, 1) == 0) ? d : -d));
            ey = coord_type'(int'(sy) + (($urandom_range(0, 1) == 0) ? d : -d));
         end
         7: begin
            ex = sx;
            ey = sy;
         end
         8: begin
            sx = corner_coord();
            sy = corner_coord();
            ex = corner_coord();
            ey = corner_coord();
         end
         9: begin
            ex = coord_type'(int'(sx) + int'($urandom_range(0, 2046)) - 1023);
            ey = coord_type'(int'(sy) + int'($urandom_range(0, 2046)) - 1023);
         end
         default: ;
      endcase
   endfunction

   // result side stalls on its own pattern, switching to a new random style after each span
   initial begin
      int style, span;
      forever begin
         style = $urandom_range(0, 4);
         span  = $urandom_range(20, 200);
         repeat (span) begin
            case (style)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 3) != 0);
               2:       rsp_tready <= ($urandom_range(0, 1) == 0);
               3:       rsp_tready <= ($urandom_range(0, 7) == 0);
               default: rsp_tready <= ($urandom_range(0, 15) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      pba_pkg::result_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.distance   = rsp_tdata[DIST_W-1:0];
         got.bearing    = rsp_tdata[DIST_W +: BEARING_W];
         got.coincident = rsp_tuser;
         if (pending_results.size() == 0) begin
            $error("unexpected result word: distance %0d bearing %0d coincident %0b",
                   got.distance, got.bearing, got.coincident);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (got.distance !== want.distance) begin
               $error("distance: expected %0d, got %0d", want.distance, got.distance);
               mismatches++;
            end
            if (got.bearing !== want.bearing) begin
               $error("bearing: expected %0d, got %0d", want.bearing, got.bearing);
               mismatches++;
            end
            if (got.coincident !== want.coincident) begin
               $error("coincident: expected %0b, got %0b", want.coincident, got.coincident);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int          burst_left, gap;
      coord_type   sx, sy, ex, ey;
      dir_row_type row;
      burst_left = 0;
      row = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int n = 0; n < DIR_LEN + RANDOM_ITEMS; n++) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
               // drop valid and scramble data while idle
               req_tvalid <= 1'b0;
               req_tdata  <= {$urandom, $urandom};
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 40);
         end
         burst_left--;
         if (n < DIR_LEN) begin
            row = DIRECTED_ROWS[n];
            sx = row.sx;
            sy = row.sy;
            ex = row.ex;
            ey = row.ey;
         end else begin
            row.typed = 1'b0;
            random_pair(sx, sy, ex, ey);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= {ey, ex, sy, sx};
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         if (row.typed)
            pending_results.push_back(pba_pkg::result_type'{distance: row.exp_dist,
                                                            bearing: row.brg,
                                                            coincident: row.coin});
         else
            pending_results.push_back(bearing_and_distance(sx, sy, ex, ey));
      end
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // hold a while longer to catch stray words
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
